// File: rtl/kps_pkg.sv
package kps_pkg;
  localparam int MAX_STATES = 8;
  localparam int MAX_JOINTS = 8;
  localparam int SW = $clog2(MAX_STATES);
  localparam int JW = $clog2(MAX_JOINTS);
  localparam int SLOTS = MAX_STATES * MAX_JOINTS;
  localparam int AW = $clog2(SLOTS);
  localparam int TW = 24;
  localparam int DW = 20;
  localparam int PW = 17 + DW;  // |d| * t magnitude width
  localparam logic [TW-1:0] TIME_MAX = '1;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_JOINT = 2'd1;
  localparam logic [1:0] OP_HEADER = 2'd2;

  localparam logic [0:0] CFG_STATE_COUNT = 1'b0;
  localparam logic [0:0] CFG_JOINT_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch input word
    logic tbl_rd;     // issue keyframe read
    logic joint0;     // do time step / transition
    logic calc;       // compute interpolation operands
    logic div_start;
    logic finish;     // form result
  } kps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
  } kps_sts_t;
endpackage

// File: rtl/kps_ram.sv
module kps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/kps_div.sv
// restoring divider, one quotient bit per cycle
module kps_div import kps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [PW-1:0] quo
);
  localparam int CW = $clog2(PW + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;

  assign busy = (cnt_r != '0);
  assign quo = q_r;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    trial = {rem_r, q_r[PW-1]};
    if (start) begin
      cnt_nxt = CW'(PW);
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt = {q_r[PW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt = {q_r[PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end
endmodule

// File: rtl/kps_ctrl.sv
module kps_ctrl import kps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_joint_zero,
  input  logic       in_tick_ok,
  output logic     out_valid,
  input  logic     out_ready,
  output kps_cmd_t cmd,
  input  kps_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic acc;

  // a new word may enter while the result register is still full, but the
  // result is only formed once the output side has drained
  assign in_ready = (st_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          cmd.capture = 1'b1;
          if (in_operation == OP_TICK && in_tick_ok) st_nxt = S_RD;
        end
      end
      S_RD: begin
        if (in_joint_zero) begin
          cmd.joint0 = 1'b1;
          st_nxt = S_STEP;
        end else begin
          cmd.tbl_rd = 1'b1;
          st_nxt = S_CALC;
        end
      end
      S_STEP: begin
        cmd.tbl_rd = 1'b1;
        st_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        st_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.div_busy) st_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!ov_r || out_ready)) else $error("result overwritten");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("result not shown");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy) else $error("divider not started");
`endif
endmodule

// File: rtl/kps_dp.sv
module kps_dp import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  kps_cmd_t    cmd,
  output kps_sts_t    sts,
  input  logic        cfg_we,
  input  logic        cfg_sel,
  input  logic [3:0]  cfg_wdata,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_state_index,
  input  logic [2:0]  in_joint_index,
  input  logic [19:0] in_time_value,
  input  logic        in_left_contact,
  input  logic        in_right_contact,
  input  logic signed [15:0] in_angle_value,
  input  logic signed [15:0] in_angle_global,
  input  logic        in_target_is_local,
  input  logic [2:0]  in_next_state,
  input  logic        in_time_mode,
  input  logic [2:0]  in_transition_contact,
  output logic        joint_zero,
  output logic        tick_ok,
  output logic signed [15:0] out_target_angle,
  output logic [2:0]  out_joint_number,
  output logic [2:0]  out_active_state,
  output logic        out_last_of_tick
);
  // captured word
  logic [1:0]  op_r;
  logic [2:0]  si_r, ji_r, ns_r, tc_r;
  logic [19:0] tv_r;
  logic        lc_r, rc_r, loc_r, tm_r;
  logic signed [15:0] av_r, ag_r;

  logic [3:0] scnt_r, jcnt_r;
  logic [SW-1:0] cur_r;
  logic [TW-1:0] tis_r;
  logic          trans_r;
  logic signed [15:0] start_r [MAX_JOINTS];
  logic [SW-1:0] nxt_r [MAX_STATES];
  logic          timed_r [MAX_STATES];
  logic [DW-1:0] dur_r [MAX_STATES];
  logic [2:0]    con_r [MAX_STATES];

  logic [16:0]   kf_rd;
  logic [16:0]   kf_wd;
  logic          kf_we;
  logic [AW-1:0] kf_wa, kf_ra;

  logic [JW-1:0] jx;
  logic [SW-1:0] sx;
  assign jx = ji_r[JW-1:0];
  assign sx = si_r[SW-1:0];
  assign joint_zero = (ji_r == 3'd0);
  assign tick_ok = (32'(in_joint_index) < MAX_JOINTS);

  // table write happens the cycle after capture
  logic wr_pend_r;
  assign kf_we = wr_pend_r && op_r == OP_JOINT && 32'(si_r) < MAX_STATES
                 && 32'(ji_r) < MAX_JOINTS;
  assign kf_wa = AW'({sx, jx});
  assign kf_wd = {loc_r, av_r};
  assign kf_ra = AW'({cur_r, jx});

  kps_ram #(.WIDTH(17), .DEPTH(SLOTS)) u_kf (
    .clk(clk), .we(kf_we), .waddr(kf_wa), .wdata(kf_wd),
    .raddr(kf_ra), .rdata(kf_rd)
  );

  // keyframe targets reset to zero: one valid bit per slot
  logic [SLOTS-1:0] kv_r;
  logic kv_hit_r;
  logic signed [15:0] tgt;
  logic tgt_loc;
  assign tgt = kv_hit_r ? kf_rd[15:0] : 16'sd0;
  assign tgt_loc = kv_hit_r && kf_rd[16];

  // time step and transition
  logic [TW:0] tsum;
  logic [2:0]  contact;
  logic        go;
  assign tsum = {1'b0, tis_r} + (TW+1)'(tv_r);
  always_comb begin
    unique case ({lc_r, rc_r})
      2'b10:   contact = 3'd1;
      2'b01:   contact = 3'd2;
      2'b11:   contact = 3'd3;
      default: contact = 3'd4;
    endcase
  end

  logic [TW-1:0] tsat;
  assign tsat = tsum[TW] ? TIME_MAX : tsum[TW-1:0];
  assign go = (scnt_r > 4'd1) &&
              (timed_r[cur_r] ? (tsat > TW'(dur_r[cur_r])) : (contact == con_r[cur_r]));

  // interpolation operands
  logic signed [15:0] st_eff;
  assign st_eff = trans_r ? (tgt_loc ? av_r : ag_r) : start_r[jx];
  logic signed [16:0] dd;
  assign dd = 17'(tgt) - 17'(st_eff);
  logic [DW-1:0] tcl;
  assign tcl = (tis_r > TW'(dur_r[cur_r])) ? dur_r[cur_r] : tis_r[DW-1:0];

  logic [16:0] mag_r;
  logic neg_r, plain_r;
  logic signed [15:0] s_r, t_r;
  logic [PW-1:0] prod;
  assign prod = PW'(mag_r) * PW'(tcl) + PW'(dur_r[cur_r] >> 1);

  logic [PW-1:0] quo;
  logic busy;
  kps_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(prod),
                 .den(dur_r[cur_r]), .busy(busy), .quo(quo));
  assign sts.div_busy = busy;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_operation; si_r <= in_state_index; ji_r <= in_joint_index;
      tv_r <= in_time_value; lc_r <= in_left_contact; rc_r <= in_right_contact;
      av_r <= in_angle_value; ag_r <= in_angle_global; loc_r <= in_target_is_local;
      ns_r <= in_next_state; tm_r <= in_time_mode; tc_r <= in_transition_contact;
    end
    if (cmd.tbl_rd) kv_hit_r <= kv_r[kf_ra];
    if (cmd.calc) begin
      mag_r <= dd[16] ? 17'(-dd) : 17'(dd);
      neg_r <= dd[16];
      s_r <= st_eff;
      t_r <= tgt;
      plain_r <= (scnt_r <= 4'd1) || !timed_r[cur_r] || (dur_r[cur_r] == '0)
                 || (st_eff == tgt);
    end
    if (cmd.finish) begin
      out_target_angle <= plain_r ? t_r :
                          (neg_r ? s_r - 16'(quo) : s_r + 16'(quo));
      out_joint_number <= ji_r;
      out_active_state <= 3'(cur_r);
      out_last_of_tick <= ({1'b0, ji_r} + 4'd1 == jcnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= 4'd1; jcnt_r <= 4'd7;
      cur_r <= '0; tis_r <= '0; trans_r <= 1'b0; wr_pend_r <= 1'b0;
      kv_r <= '0;
      for (int i = 0; i < MAX_JOINTS; i++) start_r[i] <= '0;
      for (int i = 0; i < MAX_STATES; i++) begin
        nxt_r[i] <= '0; timed_r[i] <= 1'b1; dur_r[i] <= '0; con_r[i] <= '0;
      end
    end else begin
      wr_pend_r <= cmd.capture;
      if (cfg_we) begin
        if (cfg_sel == CFG_STATE_COUNT) scnt_r <= cfg_wdata;
        else jcnt_r <= cfg_wdata;
      end
      if (kf_we) begin
        kv_r[kf_wa] <= 1'b1;
        if (si_r == 3'd0) start_r[jx] <= av_r;
      end
      if (wr_pend_r && op_r == OP_HEADER && 32'(si_r) < MAX_STATES) begin
        nxt_r[sx] <= SW'(ns_r); timed_r[sx] <= tm_r;
        dur_r[sx] <= tv_r; con_r[sx] <= tc_r;
      end
      if (cmd.joint0) begin
        if (go) begin
          tis_r <= '0; trans_r <= 1'b1; cur_r <= nxt_r[cur_r];
        end else begin
          tis_r <= tsat; trans_r <= 1'b0;
        end
      end
      if (cmd.calc && trans_r) start_r[jx] <= st_eff;
    end
  end

`ifndef ASSERT_OFF
  a_plain_dur: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && dur_r[cur_r] == '0 |-> plain_r) else $error("zero duration divided");
  a_trans_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.joint0 && go |=> tis_r == '0) else $error("time not restarted");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.joint0 && scnt_r <= 4'd1 |=> $stable(cur_r)) else $error("hold pose moved");
`endif
endmodule

// File: rtl/keyframe_pose_sequencer_core.sv
// Keyframe pose sequencer for a biped gait.
// Input channel (in_valid/in_ready): one word per table write or tick joint.
//  Operation 1 writes a joint target, 2 a state header; these give no result.
//  Operation 0 is a tick joint item; a run starts at joint 0, which advances
//  time and may take a state transition.
// Output channel (out_valid/out_ready): one word per tick item: target angle,
//  joint number, active state and a last-of-tick flag.
// Config channel (cfg_valid/cfg_ready): index 0 state_count, 1 joint_count;
//  always ready, write only while idle.
// A tick item passes a table read (after an extra time step for joint 0),
//  operand set-up, divider start, a 37-step restoring divider for the
//  interpolation (one quotient bit per step), then the result is formed.
// The next word is accepted as the result appears, so tick items do not
//  overlap; table writes leave the controller idle.
// Reset (rst_n low, synchronous) returns the state machine, time and tables
//  to their defaults; target table entries read as zero until written.
// A stalled receiver holds the result; the next word is accepted but its
//  result waits in the controller until the output register frees.
module keyframe_pose_sequencer_core import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_state_index,
  input  logic [2:0]  in_joint_index,
  input  logic [19:0] in_time_value,
  input  logic        in_left_contact,
  input  logic        in_right_contact,
  input  logic signed [15:0] in_angle_value,
  input  logic signed [15:0] in_angle_global,
  input  logic        in_target_is_local,
  input  logic [2:0]  in_next_state,
  input  logic        in_time_mode,
  input  logic [2:0]  in_transition_contact,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_target_angle,
  output logic [2:0]  out_joint_number,
  output logic [2:0]  out_active_state,
  output logic        out_last_of_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  kps_cmd_t cmd;
  kps_sts_t sts;
  logic jz, tok;

  assign cfg_ready = 1'b1;

  kps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_joint_zero(jz), .in_tick_ok(tok),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  kps_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_wdata(cfg_data),
    .in_operation(in_operation), .in_state_index(in_state_index),
    .in_joint_index(in_joint_index), .in_time_value(in_time_value),
    .in_left_contact(in_left_contact), .in_right_contact(in_right_contact),
    .in_angle_value(in_angle_value), .in_angle_global(in_angle_global),
    .in_target_is_local(in_target_is_local), .in_next_state(in_next_state),
    .in_time_mode(in_time_mode), .in_transition_contact(in_transition_contact),
    .joint_zero(jz), .tick_ok(tok),
    .out_target_angle(out_target_angle), .out_joint_number(out_joint_number),
    .out_active_state(out_active_state), .out_last_of_tick(out_last_of_tick)
  );
endmodule
